### src/psd_pkg.sv
// Shared types and constants for the port scan detector.
package psd_pkg;

    // Sizing
    localparam int SOURCES   = 16;
    localparam int PORT_KEYS = 256;
    localparam int SRC_W     = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int IP_W      = 32;
    localparam int KEY_W     = 8;
    localparam int CNT_W     = 8;
    // One row per source: port bitmap in the low bits, distinct count above it
    localparam int ROW_W     = PORT_KEYS + CNT_W;

    // Configuration port
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam logic [0:0] REG_SCAN_THRESHOLD = 1'b0;
    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd100;

    // Address table search result
    typedef struct packed {
        logic             found;
        logic [SRC_W-1:0] hit;
        logic             have_free;
        logic [SRC_W-1:0] free_idx;
    } t_cam_res;

    // Address table registration request
    typedef struct packed {
        logic             we;
        logic [SRC_W-1:0] idx;
        logic [IP_W-1:0]  ip;
    } t_cam_wr;

endpackage

### src/port_scan_detector.sv
// Port scan detector top level: event control and per-source row update.
// In the accept cycle of a SYN word the source address is searched in the address
// table and the source's row (port bitmap and distinct count) is read from the row
// RAM; in the update state the row is modified, written back for a known source
// and an unseen port without an alarm, and the result word is loaded into the
// output register. One event is in flight at a time, so a new word is taken only
// once the last is done; the update state stalls only while the output register
// still holds an untaken result. Rows carry a valid flag per source that reset,
// registration and alarms clear at once, so no clearing pass is needed after reset.
module port_scan_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Event input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [31:0] source_ip, [39:32] port_key
    // Result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] offender_ip, [39:32] distinct_ports
    output logic [2:0]  m_axis_tuser,  // [0] scan_alarm, [1] new_source, [2] table_full
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import psd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic             r_state;
    logic [IP_W-1:0]  r_ip;
    logic [KEY_W-1:0] r_key;
    t_cam_res         r_res;
    logic [SOURCES-1:0] r_rvld;

    logic             r_ovalid;
    logic [IP_W-1:0]  r_oip;
    logic [CNT_W-1:0] r_ocnt;
    logic             r_oalarm;
    logic             r_onew;
    logic             r_ofull;

    logic [CNT_W-1:0] threshold;
    t_cam_res         cam_res;
    t_cam_wr          cam_wr;
    logic             accept;
    logic             done;

    logic [ROW_W-1:0]     rdata;
    logic [ROW_W-1:0]     row;
    logic [PORT_KEYS-1:0] bitmap;
    logic [CNT_W-1:0]     cnt;
    logic [CNT_W-1:0]     cnt_inc;
    logic                 seen;
    logic                 reach;
    logic                 is_new;
    logic                 is_full;
    logic                 alarm;
    logic                 ram_we;
    logic [ROW_W-1:0]     ram_wdata;
    logic [CNT_W-1:0]     cnt_out;

    psd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_threshold (threshold)
    );

    psd_cam u_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ip    (s_axis_tdata[IP_W-1:0]),
        .i_wr    (cam_wr),
        .o_res   (cam_res)
    );

    psd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SOURCES)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_res.hit),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (cam_res.hit),
        .o_rdata (rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign done          = (r_state == ST_UPD) && (!r_ovalid || m_axis_tready);

    // Row modify: an invalid row reads as all zero
    always_comb begin
        row      = r_rvld[r_res.hit] ? rdata : '0;
        bitmap   = row[PORT_KEYS-1:0];
        cnt      = row[ROW_W-1:PORT_KEYS];
        cnt_inc  = cnt + CNT_W'(1);
        seen     = bitmap[r_key];
        reach    = (cnt_inc >= threshold);
        is_new   = !r_res.found && r_res.have_free;
        is_full  = !r_res.found && !r_res.have_free;
        alarm    = r_res.found && !seen && reach;
        ram_we   = done && r_res.found && !seen && !reach;
        ram_wdata = {cnt_inc, bitmap | (PORT_KEYS'(1) << r_key)};
        if (!r_res.found) begin
            cnt_out = '0;
        end else if (seen) begin
            cnt_out = cnt;
        end else begin
            cnt_out = cnt_inc;
        end
        cam_wr.we  = done && is_new;
        cam_wr.idx = r_res.free_idx;
        cam_wr.ip  = r_ip;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Captured event and search result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ip  <= s_axis_tdata[IP_W-1:0];
            r_key <= s_axis_tdata[IP_W+KEY_W-1:IP_W];
            r_res <= cam_res;
        end
    end

    // Row valid flags: cleared on registration and on alarm, set on write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvld <= '0;
        end else if (done) begin
            if (is_new) begin
                r_rvld[r_res.free_idx] <= 1'b0;
            end else if (alarm) begin
                r_rvld[r_res.hit] <= 1'b0;
            end else if (ram_we) begin
                r_rvld[r_res.hit] <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_oip    <= r_ip;
            r_ocnt   <= cnt_out;
            r_oalarm <= alarm;
            r_onew   <= is_new;
            r_ofull  <= is_full;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_ocnt, r_oip};
    assign m_axis_tuser  = {r_ofull, r_onew, r_oalarm};

endmodule

### src/psd_ram.sv
// Generic single-port-write, registered-read RAM.
module psd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/psd_cam.sv
// Source address table: associative search and lowest-free-entry pick.
module psd_cam (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [psd_pkg::IP_W-1:0] i_ip,
    input  psd_pkg::t_cam_wr         i_wr,
    output psd_pkg::t_cam_res        o_res
);
    import psd_pkg::*;

    logic [IP_W-1:0] r_addr  [SOURCES];
    logic [SOURCES-1:0] r_valid;
    t_cam_res n_res;

    // Registration of a new source
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            r_valid[i_wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_addr[i_wr.idx] <= i_wr.ip;
        end
    end

    // First matching valid entry, first invalid entry
    always_comb begin
        n_res = '0;
        for (int e = 0; e < SOURCES; e++) begin
            if (r_valid[e]) begin
                if (!n_res.found && r_addr[e] == i_ip) begin
                    n_res.found = 1'b1;
                    n_res.hit   = SRC_W'(e);
                end
            end else if (!n_res.have_free) begin
                n_res.have_free = 1'b1;
                n_res.free_idx  = SRC_W'(e);
            end
        end
    end

    assign o_res = n_res;

endmodule

### src/psd_cfg.sv
// APB register block holding the scan threshold.
module psd_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [psd_pkg::APB_AW-1:0] paddr,
    input  logic [psd_pkg::APB_DW-1:0] pwdata,
    output logic [psd_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output logic [psd_pkg::CNT_W-1:0]  o_threshold
);
    import psd_pkg::*;

    logic [CNT_W-1:0] r_threshold;
    logic             sel_thr;

    // Register index sits at paddr[2]
    assign sel_thr = (paddr[2] == REG_SCAN_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (psel && penable && pwrite && sel_thr) begin
            r_threshold <= pwdata[CNT_W-1:0];
        end
    end

    assign pready      = 1'b1;
    assign prdata      = sel_thr ? APB_DW'(r_threshold) : '0;
    assign o_threshold = r_threshold;

endmodule

### src/psd_checker.sv
// Port-level checks for the port scan detector, bound to the top level.
module psd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // One event in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accept");

    // A dropped or newly registered source reports no count and no alarm
    a_new_or_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[1] || m_axis_tuser[2]) |->
            !m_axis_tuser[0] && m_axis_tdata[39:32] == 8'd0
            && !(m_axis_tuser[1] && m_axis_tuser[2]))
        else $error("new or full result with count or alarm");

    // An alarm always reports a nonzero count
    a_alarm_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[39:32] != 8'd0)
        else $error("alarm with zero count");

endmodule

bind port_scan_detector psd_checker u_psd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
